// File: rtl/core/sv39ptw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sv39 page-table walker package
// Shared types and codes for the walker top level and its entry check unit.
// ----------------------------------------------------------------------------
package sv39ptw_pkg;

  localparam int EntryW = 64;
  localparam int PpnW   = 44;
  localparam int PaW    = 56;
  localparam int VpnW   = 27;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_VA_BIG       = 3'd1,
    ST_MID_INVALID  = 3'd2,
    ST_LEAF_INVALID = 3'd3,
    ST_NOT_USER     = 3'd4,
    ST_OUTSIDE      = 3'd5,
    ST_WRITTEN      = 3'd6
  } status_t;

  typedef enum logic {
    KIND_WRITE     = 1'b0,
    KIND_TRANSLATE = 1'b1
  } kind_t;

  typedef enum logic {
    REG_ROOT_PAGE = 1'b0,
    REG_BASE_PPN  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LVL2,
    S_LVL1,
    S_LVL0
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [14:0]        entry_index;
    logic [EntryW-1:0]  entry_data;
    logic [63:0]        virt_addr;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [PaW-1:0]     phys_addr;
  } out_t;

  // Verdict of the entry check unit on one fetched entry.
  typedef struct packed {
    logic    finish;
    status_t code;
  } chk_t;

  localparam int PteV = 0;
  localparam int PteU = 4;

endpackage
`default_nettype wire

// File: rtl/core/sv39_page_table_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sv39 page-table walker
// Three-level walk over an internal page-table RAM, with entry writes.
// ----------------------------------------------------------------------------
// For a write command, start is taken while busy is low, and its result appears
// on the next cycle. A translation holds busy high through S_LVL2, S_LVL1 and
// S_LVL0, one per table level, since each level needs the registered read of
// the single table RAM before the next address is known; its result shows
// back in S_IDLE, where a new start can already be taken; no new command is
// taken while a walk runs. Faults found at the start or at an upper level
// answer sooner. Results come with a one-cycle done strobe and cannot be held
// off. After reset the table RAM is cleared one word a cycle, with busy high
// until the last word is written; configuration writes are taken meanwhile.
module sv39_page_table_walker #(
  parameter int TABLE_PAGES   = 64,
  parameter int VA_LIMIT_BITS = 38
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire sv39ptw_pkg::in_t              req,
  output logic                               done,
  output sv39ptw_pkg::out_t                  rsp,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [sv39ptw_pkg::PpnW-1:0]  cfg_data
);

  localparam int SlotW = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int AddrW = SlotW + 9;
  localparam int Depth = TABLE_PAGES * 512;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  sv39ptw_pkg::state_t state, state_next;

  logic [5:0]                    root_table_page;
  logic [sv39ptw_pkg::PpnW-1:0]  store_base_ppn;
  logic [AddrW-1:0]              clr_addr;
  logic [sv39ptw_pkg::VpnW-1:0]  vpn;

  logic [sv39ptw_pkg::EntryW-1:0] mem [Depth];
  logic [sv39ptw_pkg::EntryW-1:0] rdata;
  logic                           mem_we;
  logic [AddrW-1:0]               mem_waddr;
  logic [AddrW-1:0]               mem_raddr;
  logic [sv39ptw_pkg::EntryW-1:0] mem_wdata;

  sv39ptw_pkg::out_t result_next;
  logic              done_next;

  sv39ptw_pkg::chk_t              chk;
  logic [SlotW-1:0]               chk_slot;
  logic [sv39ptw_pkg::PaW-1:0]    chk_pa;

  logic                accept;
  logic                va_big;
  logic                root_ok;
  logic [SlotW+5:0]    root_wide;
  logic [AddrW+14:0]   widx_wide;
  logic                widx_ok;

  assign busy   = (state != sv39ptw_pkg::S_IDLE);
  assign accept = start && !busy;

  assign va_big    = |req.virt_addr[63:VA_LIMIT_BITS];
  assign root_ok   = ({26'd0, root_table_page} < 32'(TABLE_PAGES));
  assign root_wide = (SlotW + 6)'(root_table_page);
  assign widx_wide = (AddrW + 15)'(req.entry_index);
  assign widx_ok   = ({17'd0, req.entry_index} < 32'(Depth));

  sv39ptw_check #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_check (
    .entry    (rdata),
    .leaf     (state == sv39ptw_pkg::S_LVL0),
    .base_ppn (store_base_ppn),
    .verdict  (chk),
    .slot     (chk_slot),
    .pa       (chk_pa)
  );

  // Table RAM: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= sv39ptw_pkg::S_CLEAR;
      clr_addr        <= '0;
      root_table_page <= '0;
      store_base_ppn  <= '0;
      done            <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == sv39ptw_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + AddrW'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          sv39ptw_pkg::REG_ROOT_PAGE: root_table_page <= cfg_data[5:0];
          sv39ptw_pkg::REG_BASE_PPN:  store_base_ppn  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rsp <= result_next;
    if (accept) begin
      vpn <= req.virt_addr[38:12];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sv39ptw_pkg::S_CLEAR: begin
        if (clr_addr == LastAddr) begin
          state_next = sv39ptw_pkg::S_IDLE;
        end
      end
      sv39ptw_pkg::S_IDLE: begin
        if (accept && req.kind == sv39ptw_pkg::KIND_TRANSLATE && !va_big && root_ok) begin
          state_next = sv39ptw_pkg::S_LVL2;
        end
      end
      sv39ptw_pkg::S_LVL2: begin
        state_next = chk.finish ? sv39ptw_pkg::S_IDLE : sv39ptw_pkg::S_LVL1;
      end
      sv39ptw_pkg::S_LVL1: begin
        state_next = chk.finish ? sv39ptw_pkg::S_IDLE : sv39ptw_pkg::S_LVL0;
      end
      sv39ptw_pkg::S_LVL0: begin
        state_next = sv39ptw_pkg::S_IDLE;
      end
      default: begin
        state_next = sv39ptw_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = clr_addr;
    mem_wdata   = '0;
    mem_raddr   = {chk_slot, vpn[17:9]};
    result_next = rsp;
    done_next   = 1'b0;
    case (state)
      sv39ptw_pkg::S_CLEAR: begin
        mem_we = 1'b1;
      end
      sv39ptw_pkg::S_IDLE: begin
        // The root-level read is issued on the same edge that takes the command.
        mem_raddr = {root_wide[SlotW-1:0], req.virt_addr[38:30]};
        if (accept) begin
          if (req.kind == sv39ptw_pkg::KIND_WRITE) begin
            mem_we      = widx_ok;
            mem_waddr   = widx_wide[AddrW-1:0];
            mem_wdata   = req.entry_data;
            result_next = '{status: sv39ptw_pkg::ST_WRITTEN, phys_addr: '0};
            done_next   = 1'b1;
          end else if (va_big) begin
            result_next = '{status: sv39ptw_pkg::ST_VA_BIG, phys_addr: '0};
            done_next   = 1'b1;
          end else if (!root_ok) begin
            result_next = '{status: sv39ptw_pkg::ST_OUTSIDE, phys_addr: '0};
            done_next   = 1'b1;
          end
        end
      end
      sv39ptw_pkg::S_LVL2: begin
        mem_raddr = {chk_slot, vpn[17:9]};
        if (chk.finish) begin
          result_next = '{status: chk.code, phys_addr: '0};
          done_next   = 1'b1;
        end
      end
      sv39ptw_pkg::S_LVL1: begin
        mem_raddr = {chk_slot, vpn[8:0]};
        if (chk.finish) begin
          result_next = '{status: chk.code, phys_addr: '0};
          done_next   = 1'b1;
        end
      end
      sv39ptw_pkg::S_LVL0: begin
        result_next.status    = chk.code;
        result_next.phys_addr = (chk.code == sv39ptw_pkg::ST_OK) ? chk_pa : '0;
        done_next             = 1'b1;
      end
      default: ;
    endcase
  end

  // A result strobe only ever follows the end of a command.
  assert property (@(posedge clk) disable iff (rst)
    done |-> state == sv39ptw_pkg::S_IDLE)
    else $error("result strobe while a walk or clearing pass is running");

  // The leaf level always answers on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    state == sv39ptw_pkg::S_LVL0 |=> done)
    else $error("leaf level finished without a result");

  // A failed or write result never carries an address.
  assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != sv39ptw_pkg::ST_OK |-> rsp.phys_addr == '0)
    else $error("nonzero address on a result that is not a translation");

  // The clearing pass only ends after the last word was cleared.
  assert property (@(posedge clk) disable iff (rst)
    $past(state) == sv39ptw_pkg::S_CLEAR && state == sv39ptw_pkg::S_IDLE
    |-> $past(clr_addr) == LastAddr)
    else $error("clearing pass ended early");

endmodule
`default_nettype wire

// File: rtl/core/sv39ptw_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sv39 walker entry check unit
// Judges one fetched page-table entry and maps its PPN into the store window.
// ----------------------------------------------------------------------------
module sv39ptw_check #(
  parameter int TABLE_PAGES = 64
) (
  input  wire logic [sv39ptw_pkg::EntryW-1:0]  entry,
  input  wire logic                            leaf,
  input  wire logic [sv39ptw_pkg::PpnW-1:0]    base_ppn,
  output sv39ptw_pkg::chk_t                    verdict,
  output logic [((TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1)-1:0] slot,
  output logic [sv39ptw_pkg::PaW-1:0]          pa
);

  localparam int SlotW = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int PpnW  = sv39ptw_pkg::PpnW;

  logic [PpnW-1:0] ppn;
  logic [PpnW:0]   diff;
  logic            outside;

  assign ppn = entry[PpnW+9:10];

  // The borrow out of the subtraction flags a PPN below the window base.
  assign diff    = {1'b0, ppn} - {1'b0, base_ppn};
  assign outside = diff[PpnW] || (diff[PpnW-1:0] >= PpnW'(TABLE_PAGES));
  assign slot    = diff[SlotW-1:0];
  assign pa      = {ppn, 12'd0};

  always_comb begin
    verdict.finish = 1'b1;
    verdict.code   = sv39ptw_pkg::ST_OK;
    if (leaf) begin
      if (!entry[sv39ptw_pkg::PteV]) begin
        verdict.code = sv39ptw_pkg::ST_LEAF_INVALID;
      end else if (!entry[sv39ptw_pkg::PteU]) begin
        verdict.code = sv39ptw_pkg::ST_NOT_USER;
      end
    end else begin
      if (!entry[sv39ptw_pkg::PteV]) begin
        verdict.code = sv39ptw_pkg::ST_MID_INVALID;
      end else if (outside) begin
        verdict.code = sv39ptw_pkg::ST_OUTSIDE;
      end else begin
        verdict.finish = 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/sv39_walk_checker.sv
// ----------------------------------------------------------------------------
// Sv39 walk checker
// Watches the command, result and register ports of the page-table walker,
// keeps its own copy of the table store and registers, predicts the result
// of every accepted command and compares each result against the oldest one.
// ----------------------------------------------------------------------------
module sv39_walk_checker
  import sv39ptw_pkg::*;
#(
  parameter int TABLE_PAGES   = 64,
  parameter int VA_LIMIT_BITS = 38
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire in_t              req,
  input  wire logic             done,
  input  wire out_t             rsp,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [PpnW-1:0]  cfg_data,
  output int unsigned           fail_count,
  output int unsigned           outstanding,
  output int unsigned           checked,
  output int unsigned           pages_found
);

  localparam int StoreWords = TABLE_PAGES * 512;

  logic [EntryW-1:0] table_copy [StoreWords];
  logic [5:0]        root_slot;
  logic [PpnW-1:0]   base_ppn;
  out_t              pending_rsp [$];
  int unsigned       n_fail;
  int unsigned       n_checked;
  int unsigned       n_found;

  // Applies a write to the table copy, or walks the three levels for a
  // translation, and returns the result the block should give.
  function automatic out_t predict_response(input in_t item);
    out_t              r;
    logic [EntryW-1:0] pte;
    logic [PpnW-1:0]   ppn;
    logic [PpnW-1:0]   slot;
    r.status    = ST_OK;
    r.phys_addr = '0;
    if (item.kind == KIND_WRITE) begin
      if (item.entry_index < StoreWords) table_copy[item.entry_index] = item.entry_data;
      r.status = ST_WRITTEN;
      return r;
    end
    if ((item.virt_addr >> VA_LIMIT_BITS) != 0) begin
      r.status = ST_VA_BIG;
      return r;
    end
    if (root_slot >= TABLE_PAGES) begin
      r.status = ST_OUTSIDE;
      return r;
    end
    slot = PpnW'(root_slot);
    for (int lvl = 2; lvl >= 0; lvl--) begin
      pte = table_copy[slot * 512 + item.virt_addr[12 + 9 * lvl +: 9]];
      if (!pte[PteV]) begin
        r.status = (lvl == 0) ? ST_LEAF_INVALID : ST_MID_INVALID;
        return r;
      end
      ppn = pte[10 +: PpnW];
      if (lvl == 0) begin
        if (!pte[PteU]) begin
          r.status = ST_NOT_USER;
          return r;
        end
        r.phys_addr = {ppn, 12'b0};
        return r;
      end
      // Upper-level entries are followed as pointers whatever their R/W/X bits.
      if (ppn < base_ppn || ppn - base_ppn >= TABLE_PAGES) begin
        r.status = ST_OUTSIDE;
        return r;
      end
      slot = ppn - base_ppn;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input out_t want, input out_t got);
    n_fail++;
    if (n_fail <= 10) begin
      $display("MISMATCH (%s): expected status %0d pa 0x%014h, got status %0d pa 0x%014h",
               what, want.status, want.phys_addr, got.status, got.phys_addr);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      for (int i = 0; i < StoreWords; i++) table_copy[i] = '0;
      root_slot = '0;
      base_ppn  = '0;
      pending_rsp.delete();
    end else begin
      if ($isunknown(done)) begin
        report_mismatch("unknown done strobe", '0, rsp);
      end else if (done) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("result with nothing pending", '0, rsp);
        end else begin
          want = pending_rsp.pop_front();
          n_checked++;
          if (rsp.status !== want.status || rsp.phys_addr !== want.phys_addr) begin
            report_mismatch("result fields", want, rsp);
          end else if (want.status == ST_OK) begin
            n_found++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_ROOT_PAGE) root_slot = cfg_data[5:0];
        else base_ppn = cfg_data;
      end
      // A command transfer happens at the edge where start is high and busy is low.
      if (start && !busy) pending_rsp.push_back(predict_response(req));
    end
    fail_count  <= n_fail;
    outstanding <= pending_rsp.size();
    checked     <= n_checked;
    pages_found <= n_found;
  end

endmodule

// File: tb/tb_sv39_page_table_walker.sv
// ----------------------------------------------------------------------------
// Sv39 page-table walker testbench
// Drives table writes and translations in random bursts: a directed set of
// corner cases first, then phases under several root and base settings that
// build three-level mappings, half of them with one flaw, and walk them.
// ----------------------------------------------------------------------------
module tb_sv39_page_table_walker;
  import sv39ptw_pkg::*;

  localparam int TABLE_PAGES    = 64;
  localparam int VA_LIMIT_BITS  = 38;
  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 6;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 63;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TIMEOUT_CYCLES = 300000;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  in_t              req       = '0;
  logic             cfg_we    = 1'b0;
  cfg_reg_t         cfg_index = REG_ROOT_PAGE;
  logic [PpnW-1:0]  cfg_data  = '0;
  logic             busy;
  logic             done;
  out_t             rsp;

  int unsigned      fail_count;
  int unsigned      outstanding;
  int unsigned      checked;
  int unsigned      pages_found;

  int               burst_left;
  int unsigned      n_writes;
  int unsigned      n_walks;
  int unsigned      n_settings;
  logic [5:0]       cur_root;
  logic [PpnW-1:0]  cur_base;
  logic [26:0]      mapped_vpns [$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  sv39_page_table_walker #(
    .TABLE_PAGES  (TABLE_PAGES),
    .VA_LIMIT_BITS(VA_LIMIT_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  sv39_walk_checker #(
    .TABLE_PAGES  (TABLE_PAGES),
    .VA_LIMIT_BITS(VA_LIMIT_BITS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .outstanding(outstanding),
    .checked    (checked),
    .pages_found(pages_found)
  );

  // Fields that the command kind does not use still get random values.
  function automatic in_t make_write(input logic [14:0] idx, input logic [63:0] data);
    in_t it;
    it.kind        = KIND_WRITE;
    it.entry_index = idx;
    it.entry_data  = data;
    it.virt_addr   = {$urandom, $urandom};
    return it;
  endfunction

  function automatic in_t make_walk(input logic [63:0] va);
    in_t it;
    it.kind        = KIND_TRANSLATE;
    it.entry_index = 15'($urandom);
    it.entry_data  = {$urandom, $urandom};
    it.virt_addr   = va;
    return it;
  endfunction

  function automatic logic [63:0] pointer_pte(input logic [PpnW-1:0] ppn);
    return {10'($urandom), ppn, 10'($urandom) | 10'h001};
  endfunction

  function automatic logic [63:0] leaf_pte(input logic [PpnW-1:0] ppn);
    return {10'($urandom), ppn, 10'($urandom) | 10'h011};
  endfunction

  // Holds one command on the port until its transfer, then ends the burst
  // with a random gap when the burst runs out.
  task automatic issue(input in_t item);
    start <= 1'b1;
    req   <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (item.kind == KIND_WRITE) n_writes++;
    else n_walks++;
    burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_config(input logic [5:0] root, input logic [PpnW-1:0] base);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROOT_PAGE;
    cfg_data  <= PpnW'(root);
    @(posedge clk);
    cfg_index <= REG_BASE_PPN;
    cfg_data  <= base;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_root = root;
    cur_base = base;
    n_settings++;
  endtask

  initial begin
    int unsigned     phase_start;
    int              pick;
    logic [5:0]      root;
    logic [PpnW-1:0] base;
    logic [8:0]      i2, i1, i0;
    logic [5:0]      sa, sb;
    logic [63:0]     p2, p1, leaf;
    logic [26:0]     vpn;
    burst_left = $urandom_range(1, 10);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    // The store is being cleared now; register writes are taken meanwhile.
    set_config('0, '0);

    // Corner cases with the root in slot 0 and slot 0 at physical page 0.
    issue(make_walk('0));
    issue(make_walk(64'd1 << VA_LIMIT_BITS));
    issue(make_walk('1));
    issue(make_walk((64'd1 << VA_LIMIT_BITS) - 1));
    // Upper-level pointer with reserved and R/W/X bits set.
    issue(make_write({6'd0, 9'd0}, {10'h3FF, 44'd1, 10'h00F}));
    issue(make_write({6'd1, 9'd0}, {10'h000, 44'd2, 10'h001}));
    issue(make_walk(64'h0));
    issue(make_write({6'd2, 9'd0}, {10'h000, 44'hABC, 10'h001}));
    issue(make_walk(64'hFFF));
    issue(make_write({6'd2, 9'd0}, '1));
    issue(make_walk(64'h123));
    issue(make_write({6'd2, 9'd0}, {10'h000, 44'd0, 10'h011}));
    issue(make_walk(64'h0));
    // Top-level pointer just past the store window, middle-level one far past.
    issue(make_write({6'd0, 9'd1}, {10'h000, 44'd64, 10'h001}));
    issue(make_walk(64'h4000_0000));
    issue(make_write({6'd1, 9'd1}, {10'h000, 44'hFFF_FFFF_FFFF, 10'h001}));
    issue(make_walk(64'h20_0000));
    issue(make_write({6'd1, 9'd2}, ~64'd1));
    issue(make_walk(64'h40_0000));
    // Highest legal address through the last slot, whose last entry serves
    // both as the middle pointer and as the leaf.
    issue(make_write(15'h7FFF, '1));
    issue(make_write({6'd0, 9'd255}, {10'h000, 44'd63, 10'h001}));
    issue(make_write({6'd63, 9'd511}, {10'h155, 44'd63, 10'h01F}));
    issue(make_walk((64'd1 << VA_LIMIT_BITS) - 1));

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          root = 6'd63;
          base = '1;
        end
        1: begin
          root = 6'd0;
          base = 44'hFFF_FFFF_FFC0;
        end
        2: begin
          root = 6'($urandom);
          base = PpnW'({$urandom, $urandom});
        end
        3: begin
          root = 6'($urandom);
          base = '0;
        end
        4: begin
          root = 6'($urandom);
          base = PpnW'($urandom_range(1, 200));
        end
        default: begin
          root = 6'($urandom);
          base = PpnW'($urandom);
        end
      endcase
      set_config(root, base);
      mapped_vpns.delete();
      phase_start = n_writes + n_walks;
      while (n_writes + n_walks - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          // Build a three-level mapping, half the time with a flaw, and walk it.
          i2   = 9'($urandom_range(0, (1 << (VA_LIMIT_BITS - 30)) - 1));
          i1   = 9'($urandom);
          i0   = 9'($urandom);
          sa   = 6'($urandom);
          sb   = 6'($urandom);
          p2   = pointer_pte(cur_base + PpnW'(sa));
          p1   = pointer_pte(cur_base + PpnW'(sb));
          leaf = leaf_pte(PpnW'({$urandom, $urandom}));
          case ($urandom_range(0, 11))
            0: p2[PteV] = 1'b0;
            1: p1[PteV] = 1'b0;
            2: p1[10 +: PpnW] = cur_base + PpnW'(TABLE_PAGES + $urandom_range(0, 3));
            3: p2[10 +: PpnW] = cur_base - PpnW'($urandom_range(1, 4));
            4: leaf[PteV] = 1'b0;
            5: leaf[PteU] = 1'b0;
            default: ;
          endcase
          vpn = {i2, i1, i0};
          issue(make_write({cur_root, i2}, p2));
          issue(make_write({sa, i1}, p1));
          issue(make_write({sb, i0}, leaf));
          repeat ($urandom_range(1, 2)) issue(make_walk({25'b0, vpn, 12'($urandom)}));
          mapped_vpns.push_back(vpn);
        end else if (pick < 70 && mapped_vpns.size() != 0) begin
          vpn = mapped_vpns[$urandom_range(0, mapped_vpns.size() - 1)];
          issue(make_walk({25'b0, vpn, 12'($urandom)}));
        end else if (pick < 85) begin
          issue(make_write(15'($urandom), {$urandom, $urandom}));
        end else if ($urandom_range(0, 1) == 1) begin
          issue(make_walk({$urandom, $urandom}));
        end else begin
          issue(make_walk({$urandom, $urandom} & ((64'd1 << VA_LIMIT_BITS) - 1)));
        end
      end
    end
    settle();

    $display("Run covered %0d table writes and %0d translations under %0d register settings.",
             n_writes, n_walks, n_settings);
    $display("%0d results were checked; %0d translations resolved to a page.",
             checked, pages_found);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Run timed out with %0d results outstanding.", outstanding);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sv39_page_table_walker.f
rtl/core/sv39ptw_pkg.sv
rtl/core/sv39ptw_check.sv
rtl/core/sv39_page_table_walker.sv
tb/sv39_walk_checker.sv
tb/tb_sv39_page_table_walker.sv
